// ===== rtl/hsl_pkg.sv =====
// Shared types and constants for the HSL to RGB converter.
// Used by hsl_front, hsl_fifo, hsl_back and hsl_to_rgb_converter.
`default_nettype none

package hsl_pkg;

  // Field widths
  localparam int HUE_W    = 9;
  localparam int CH_W     = 8;
  localparam int WEIGHT_W = 6;
  localparam int PHASE_W  = 7;

  // Hue geometry in whole degrees
  localparam logic [HUE_W-1:0] HUE_TURN = 9'd360;
  localparam logic [HUE_W-1:0] DEG_60   = 9'd60;
  localparam logic [HUE_W-1:0] DEG_120  = 9'd120;
  localparam logic [HUE_W-1:0] DEG_180  = 9'd180;
  localparam logic [HUE_W-1:0] DEG_240  = 9'd240;
  localparam logic [HUE_W-1:0] DEG_300  = 9'd300;

  // Full scale of saturation and lightness
  localparam logic [CH_W-1:0] UNIT_SCALE = 8'd255;

  // floor(p / 60) for p < 2^14 as (p * DIV60_RECIP) >> DIV60_SHIFT
  localparam int               DIV60_SHIFT = 20;
  localparam logic [14:0]      DIV60_RECIP = 15'd17477;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // Hue sextant, names follow the hue range it covers
  typedef enum logic [2:0] {
    SEXT_RED_YEL = 3'd0,
    SEXT_YEL_GRN = 3'd1,
    SEXT_GRN_CYN = 3'd2,
    SEXT_CYN_BLU = 3'd3,
    SEXT_BLU_MAG = 3'd4,
    SEXT_MAG_RED = 3'd5
  } sextant_t;

  // Classified pixel word handed from front to back
  typedef struct packed {
    sextant_t              sext;
    logic [WEIGHT_W-1:0]   weight;  // 60 - |(h mod 120) - 60|
    logic [CH_W-1:0]       base;    // 255 - |2L - 255|
    logic [CH_W-1:0]       sat;
    logic [CH_W-1:0]       light;
  } hsl_item_t;

  // Queue status seen by the front
  typedef struct packed {
    logic full;
    logic empty;
  } hsl_qstat_t;

endpackage

`default_nettype wire

// ===== rtl/hsl_to_rgb_converter.sv =====
// HSL to RGB converter top level: front classifier, queue, back pipeline.
// Depends on hsl_pkg, hsl_front, hsl_fifo and hsl_back.
//
//   channel  | signals                              | handshake
//   ---------+--------------------------------------+-----------------------
//   pixel in | hue, saturation, lightness           | start && !busy
//   color out| red, green, blue                     | done, one-cycle strobe
//
// One pixel per clock sustained. An accepted pixel passes through one front
// register, one queue slot and five back stages (multiply, divide by 255,
// multiply, divide by 60, add and clamp). The back pipeline never stalls, so
// the queue holds at most one word and busy stays low. Reset is synchronous
// and clears all valid state.
`default_nettype none

module hsl_to_rgb_converter (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [hsl_pkg::HUE_W-1:0] hue,
  input  wire logic [hsl_pkg::CH_W-1:0]  saturation,
  input  wire logic [hsl_pkg::CH_W-1:0]  lightness,
  output logic                           done,
  output logic [hsl_pkg::CH_W-1:0]       red,
  output logic [hsl_pkg::CH_W-1:0]       green,
  output logic [hsl_pkg::CH_W-1:0]       blue
);
  import hsl_pkg::*;

  logic       q_push;
  logic       q_pop;
  hsl_item_t  front_item;
  hsl_item_t  back_item;
  hsl_qstat_t qstat;

  // Back drains the queue every cycle it has a word
  assign q_pop = !qstat.empty;

  hsl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .hue        (hue),
    .saturation (saturation),
    .lightness  (lightness),
    .qstat      (qstat),
    .busy       (busy),
    .push       (q_push),
    .item       (front_item)
  );

  hsl_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (front_item),
    .pop       (q_pop),
    .pop_item  (back_item),
    .qstat     (qstat)
  );

  hsl_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (q_pop),
    .in_item  (back_item),
    .done     (done),
    .red      (red),
    .green    (green),
    .blue     (blue)
  );

`ifndef NO_ASSERTIONS
  // Front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && qstat.full))
    else $error("push into full queue");

  // Back drains every cycle, so the front never has to hold off
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy asserted");

  // Every accepted word yields its result
  a_accept_to_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##7 done)
    else $error("result missing after accept");

  // No result without a matching accept
  a_done_has_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 7))
    else $error("result without accept");
`endif

endmodule

`default_nettype wire

// ===== rtl/hsl_front.sv =====
// Front part: accepts a pixel, reduces the hue and classifies it into
// sextant, ramp weight and chroma base. Depends on hsl_pkg.
`default_nettype none

module hsl_front (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [hsl_pkg::HUE_W-1:0] hue,
  input  wire logic [hsl_pkg::CH_W-1:0]  saturation,
  input  wire logic [hsl_pkg::CH_W-1:0]  lightness,
  input  wire hsl_pkg::hsl_qstat_t      qstat,
  output logic                          busy,
  output logic                          push,
  output hsl_pkg::hsl_item_t            item
);
  import hsl_pkg::*;

  logic                 valid;
  logic                 accept;
  logic [HUE_W-1:0]     hue_mod;
  sextant_t             sext;
  logic [HUE_W-1:0]     phase_base;
  logic [PHASE_W-1:0]   phase;
  logic [WEIGHT_W-1:0]  off;
  logic [HUE_W-1:0]     twice_l;
  logic [HUE_W-1:0]     l_dev;
  hsl_item_t            item_next;

  // Handshake: hold the word while the queue is full
  assign push   = valid && !qstat.full;
  assign busy   = valid && qstat.full;
  assign accept = start && !busy;

  // Hue reduction and sextant
  always_comb begin
    hue_mod = (hue >= HUE_TURN) ? hue - HUE_TURN : hue;
    if (hue_mod < DEG_60) begin
      sext = SEXT_RED_YEL;
    end else if (hue_mod < DEG_120) begin
      sext = SEXT_YEL_GRN;
    end else if (hue_mod < DEG_180) begin
      sext = SEXT_GRN_CYN;
    end else if (hue_mod < DEG_240) begin
      sext = SEXT_CYN_BLU;
    end else if (hue_mod < DEG_300) begin
      sext = SEXT_BLU_MAG;
    end else begin
      sext = SEXT_MAG_RED;
    end
  end

  // Position inside the 120 degree period and ramp weight
  always_comb begin
    case (sext)
      SEXT_RED_YEL, SEXT_YEL_GRN: phase_base = '0;
      SEXT_GRN_CYN, SEXT_CYN_BLU: phase_base = DEG_120;
      default:                    phase_base = DEG_240;
    endcase
    phase = PHASE_W'(hue_mod - phase_base);
    off   = (phase >= PHASE_W'(DEG_60)) ? WEIGHT_W'(phase - PHASE_W'(DEG_60))
                                        : WEIGHT_W'(PHASE_W'(DEG_60) - phase);
  end

  // Chroma base from lightness
  always_comb begin
    twice_l = {lightness, 1'b0};
    l_dev   = (twice_l >= {1'b0, UNIT_SCALE}) ? twice_l - {1'b0, UNIT_SCALE}
                                              : {1'b0, UNIT_SCALE} - twice_l;
    item_next.sext   = sext;
    item_next.weight = WEIGHT_W'(DEG_60) - off;
    item_next.base   = UNIT_SCALE - CH_W'(l_dev);
    item_next.sat    = saturation;
    item_next.light  = lightness;
  end

  // Front register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept) begin
      valid <= 1'b1;
    end else if (push) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hsl_fifo.sv =====
// Short queue of classified pixel words between front and back.
// Depends on hsl_pkg.
`default_nettype none

module hsl_fifo (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire hsl_pkg::hsl_item_t push_item,
  input  wire logic               pop,
  output hsl_pkg::hsl_item_t      pop_item,
  output hsl_pkg::hsl_qstat_t     qstat
);
  import hsl_pkg::*;

  hsl_item_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_push;
  logic               do_pop;

  assign qstat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign pop_item    = entries[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hsl_back.sv =====
// Back part: five-stage pipeline computing chroma, ramp value, offset and
// the three saturated channels. Depends on hsl_pkg.
`default_nettype none

module hsl_back (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  input  wire hsl_pkg::hsl_item_t      in_item,
  output logic                         done,
  output logic [hsl_pkg::CH_W-1:0]     red,
  output logic [hsl_pkg::CH_W-1:0]     green,
  output logic [hsl_pkg::CH_W-1:0]     blue
);
  import hsl_pkg::*;

  // Stage valids
  logic v1, v2, v3, v4;

  // Stage 1: base * saturation
  logic [2*CH_W-1:0]   s1_prod;
  sextant_t            s1_sext;
  logic [WEIGHT_W-1:0] s1_weight;
  logic [CH_W-1:0]     s1_light;

  // Stage 2: chroma = prod / 255
  logic [2*CH_W:0]     s1_div_sum;
  logic [CH_W-1:0]     s2_c;
  sextant_t            s2_sext;
  logic [WEIGHT_W-1:0] s2_weight;
  logic [CH_W-1:0]     s2_light;

  // Stage 3: chroma * weight and offset m
  logic [CH_W-1:0]          s2_half;
  logic [CH_W+WEIGHT_W-1:0] s3_prod;
  logic [CH_W-1:0]          s3_c;
  logic [CH_W-1:0]          s3_m;
  sextant_t                 s3_sext;

  // Stage 4: ramp value = prod / 60
  logic [CH_W+WEIGHT_W+15-1:0] s3_recip;
  logic [CH_W-1:0]             s4_x;
  logic [CH_W-1:0]             s4_c;
  logic [CH_W-1:0]             s4_m;
  sextant_t                    s4_sext;

  // Stage 5 channel placement
  logic [CH_W-1:0] r_raw, g_raw, b_raw;
  logic [CH_W:0]   r_sum, g_sum, b_sum;

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= in_valid;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      done <= v4;
    end
  end

  // Exact floor(p / 255) for p < 2^16 - 1: (p + (p >> 8) + 1) >> 8
  assign s1_div_sum = {1'b0, s1_prod} + {9'd0, s1_prod[2*CH_W-1:CH_W]} + 17'd1;
  assign s2_half    = s2_c >> 1;
  assign s3_recip   = (CH_W+WEIGHT_W+15)'(s3_prod) * (CH_W+WEIGHT_W+15)'(DIV60_RECIP);

  // Datapath registers
  always_ff @(posedge clk) begin
    s1_prod   <= (2*CH_W)'(in_item.base) * (2*CH_W)'(in_item.sat);
    s1_sext   <= in_item.sext;
    s1_weight <= in_item.weight;
    s1_light  <= in_item.light;

    s2_c      <= s1_div_sum[2*CH_W-1:CH_W];
    s2_sext   <= s1_sext;
    s2_weight <= s1_weight;
    s2_light  <= s1_light;

    s3_prod   <= (CH_W+WEIGHT_W)'(s2_c) * (CH_W+WEIGHT_W)'(s2_weight);
    s3_c      <= s2_c;
    s3_m      <= (s2_light >= s2_half) ? s2_light - s2_half : '0;
    s3_sext   <= s2_sext;

    s4_x      <= s3_recip[DIV60_SHIFT +: CH_W];
    s4_c      <= s3_c;
    s4_m      <= s3_m;
    s4_sext   <= s3_sext;

    red       <= r_sum[CH_W] ? UNIT_SCALE : r_sum[CH_W-1:0];
    green     <= g_sum[CH_W] ? UNIT_SCALE : g_sum[CH_W-1:0];
    blue      <= b_sum[CH_W] ? UNIT_SCALE : b_sum[CH_W-1:0];
  end

  // Place chroma and ramp by sextant, then add offset
  always_comb begin
    case (s4_sext)
      SEXT_RED_YEL: begin r_raw = s4_c; g_raw = s4_x; b_raw = '0;   end
      SEXT_YEL_GRN: begin r_raw = s4_x; g_raw = s4_c; b_raw = '0;   end
      SEXT_GRN_CYN: begin r_raw = '0;   g_raw = s4_c; b_raw = s4_x; end
      SEXT_CYN_BLU: begin r_raw = '0;   g_raw = s4_x; b_raw = s4_c; end
      SEXT_BLU_MAG: begin r_raw = s4_x; g_raw = '0;   b_raw = s4_c; end
      default:      begin r_raw = s4_c; g_raw = '0;   b_raw = s4_x; end
    endcase
    r_sum = {1'b0, r_raw} + {1'b0, s4_m};
    g_sum = {1'b0, g_raw} + {1'b0, s4_m};
    b_sum = {1'b0, b_raw} + {1'b0, s4_m};
  end

endmodule

`default_nettype wire

// ===== dv/tb_hsl_to_rgb_converter.sv =====
// Self-checking testbench for hsl_to_rgb_converter: directed corners, then random pixels.
// Depends on hsl_pkg for the field widths, hue constants and the sextant enum.
`default_nettype none

module tb_hsl_to_rgb_converter;
  import hsl_pkg::*;

  localparam int unsigned RANDOM_PIXELS  = 500;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 12;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic [HUE_W-1:0] hue = '0;
  logic [CH_W-1:0]  saturation = '0;
  logic [CH_W-1:0]  lightness = '0;
  logic             busy;
  logic             done;
  logic [CH_W-1:0]  red;
  logic [CH_W-1:0]  green;
  logic [CH_W-1:0]  blue;
  int unsigned      quiet_cycles = 0;

  // corner values for directed and pulled random words
  logic [HUE_W-1:0] hue_edges[16] = '{0, 1, 59, 60, 119, 120, 179, 180,
                                      239, 240, 299, 300, 359, 360, 419, 511};
  logic [CH_W-1:0]  level_edges[6] = '{0, 1, 127, 128, 254, 255};

  hsl_to_rgb_converter dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .hue        (hue),
    .saturation (saturation),
    .lightness  (lightness),
    .done       (done),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

  always #5 clk = ~clk;

  function automatic logic [CH_W-1:0] clamp_channel(int unsigned v);
    return (v > UNIT_SCALE) ? UNIT_SCALE : v[CH_W-1:0];
  endfunction

  // Integer HSL to RGB: chroma, intermediate and offset all in 1/255 units
  function automatic rgb_t hsl_to_rgb(logic [HUE_W-1:0] h_in, logic [CH_W-1:0] s_in,
                                      logic [CH_W-1:0] l_in);
    int unsigned h, s, l, l_dev, chroma, phase, off, inter, offset, r, g, b;
    rgb_t color;
    h = h_in;
    h = h % HUE_TURN;
    s = s_in;
    l = l_in;
    l_dev = (2 * l >= UNIT_SCALE) ? 2 * l - UNIT_SCALE : UNIT_SCALE - 2 * l;
    chroma = ((UNIT_SCALE - l_dev) * s) / UNIT_SCALE;
    phase = h % DEG_120;
    off = (phase >= DEG_60) ? phase - DEG_60 : DEG_60 - phase;
    inter = (chroma * (DEG_60 - off)) / DEG_60;
    offset = (l >= chroma / 2) ? l - chroma / 2 : 0;
    // sextant decides where chroma and the intermediate land
    case (sextant_t'(h / DEG_60))
      SEXT_RED_YEL: begin r = chroma; g = inter;  b = 0;      end
      SEXT_YEL_GRN: begin r = inter;  g = chroma; b = 0;      end
      SEXT_GRN_CYN: begin r = 0;      g = chroma; b = inter;  end
      SEXT_CYN_BLU: begin r = 0;      g = inter;  b = chroma; end
      SEXT_BLU_MAG: begin r = inter;  g = 0;      b = chroma; end
      default:      begin r = chroma; g = 0;      b = inter;  end
    endcase
    color.red   = clamp_channel(r + offset);
    color.green = clamp_channel(g + offset);
    color.blue  = clamp_channel(b + offset);
    return color;
  endfunction

  // Holds expected colors in order of accepted pixel words
  class rgb_scoreboard;
    rgb_t        expected_colors[$];
    int unsigned mismatches = 0;

    function void note_pixel(logic [HUE_W-1:0] h, logic [CH_W-1:0] s, logic [CH_W-1:0] l);
      expected_colors.push_back(hsl_to_rgb(h, s, l));
    endfunction

    function void check_color(rgb_t got);
      rgb_t want;
      if (expected_colors.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected color word: r=%0d g=%0d b=%0d", got.red, got.green, got.blue);
        return;
      end
      want = expected_colors.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("color mismatch at %0t: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                   $realtime, want.red, want.green, want.blue, got.red, got.green, got.blue);
      end
    endfunction
  endclass

  rgb_scoreboard colors = new;

  // Monitor: pixel words in, color words out, and the watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy)
        colors.note_pixel(hue, saturation, lightness);
      if (done)
        colors.check_color(rgb_t'{red, green, blue});
      if ((start && !busy) || done)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Drive one pixel word, idling first with the given odds, hold until taken
  task automatic send_pixel(logic [HUE_W-1:0] h, logic [CH_W-1:0] s, logic [CH_W-1:0] l,
                            int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    hue        <= h;
    saturation <= s;
    lightness  <= l;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    int unsigned idle_pct;
    int unsigned kind;
    logic [HUE_W-1:0] h;
    logic [CH_W-1:0]  s;
    logic [CH_W-1:0]  l;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: every sextant boundary, wrap of hue, grey, black, white
    foreach (hue_edges[i])
      send_pixel(hue_edges[i], 8'd255, (i % 2) ? 8'd127 : 8'd128, 0);
    send_pixel(9'd200, 8'd0, 8'd128, 0);
    send_pixel(9'd45, 8'd255, 8'd0, 0);
    send_pixel(9'd45, 8'd255, 8'd255, 0);
    send_pixel(9'd90, 8'd1, 8'd1, 0);
    send_pixel(9'd330, 8'd170, 8'd200, 0);
    send_pixel(9'd511, 8'd255, 8'd254, 0);
    send_pixel(9'd400, 8'd128, 8'd64, 0);

    // random: four idling phases, some words pulled toward corners
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        1:       idle_pct = 54;
        3:       idle_pct = 37;
        default: idle_pct = 0;
      endcase
      for (int n = 0; n < RANDOM_PIXELS / 4; n++) begin
        kind = $urandom_range(9);
        h = HUE_W'($urandom_range(511));
        s = CH_W'($urandom_range(255));
        l = CH_W'($urandom_range(255));
        if (kind >= 7) begin
          h = hue_edges[$urandom_range(15)];
          s = level_edges[$urandom_range(5)];
          l = level_edges[$urandom_range(5)];
        end
        send_pixel(h, s, l, idle_pct);
      end
    end
    start <= 1'b0;

    // drain
    while (colors.expected_colors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (colors.mismatches == 0 && colors.expected_colors.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire
